@@ rtl/ltc_pkg.sv @@
// Shared types and constants for the looper transport controller.
// Used by ltc_core and looper_transport_controller; depends on nothing else.
package ltc_pkg;

  // Loop store geometry.
  localparam int LOOP_FRAMES = 4096;
  localparam int POS_W       = $clog2(LOOP_FRAMES);
  localparam int LEN_W       = POS_W + 1;

  // Transport modes.
  localparam logic [1:0] MODE_BYPASS  = 2'd0;
  localparam logic [1:0] MODE_RECORD  = 2'd1;
  localparam logic [1:0] MODE_OVERDUB = 2'd2;
  localparam logic [1:0] MODE_PLAY    = 2'd3;

  // Frame actions toward the loop store.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RMW   = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  // Request operations.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // Timing and LED constants.
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [31:0] FAST_BLINK_MASK  = 32'h0000_0040;
  localparam logic [31:0] SLOW_BLINK_MASK  = 32'h0000_0080;
  localparam int          PLAY_LED_POS     = 5;

  // One accepted request.
  typedef struct packed {
    logic        operation;
    logic        button_level;
    logic [31:0] tick_time;
  } ltc_item_t;

  // One result.
  typedef struct packed {
    logic [1:0]       frame_action;
    logic [POS_W-1:0] frame_index;
    logic             led_on;
    logic             engaged;
    logic [1:0]       mode_now;
  } ltc_result_t;

endpackage

@@ rtl/looper_transport_controller.sv @@
// Top level of the looper transport controller: request and result channels,
// pipeline registers and the long press register. Uses ltc_pkg and ltc_core.
//
// Usage: each request on the in_ channel is either a tick carrying a button
// sample and the tick count, or a codec frame boundary. Every request gives
// exactly one result on the out_ channel: the loop store action and index
// for a frame, the LED level, the engaged flag and the mode after it.
// A request is taken when in_valid is high and in_stall is low; a result
// is taken when out_valid is high and out_stall is low.
// A request is registered in the request register, processed by ltc_core and
// registered again in the result register, which drives out_.
// Throughput: one request per cycle while out_stall is low, set by the
// single pass of transport logic between the request and result registers.
// When the receiver stalls, the result register holds and the request
// register fills; in_stall rises only when both are occupied.
// The cfg_ channel writes long_press_ticks; cfg_ready is always high. Writes
// must be made while no request is in flight; the block does not enforce it.
// Reset clears both pipeline stages, sets bypass mode, zero position and
// length, a released button, LED off and long_press_ticks to 1000.
module looper_transport_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic        in_button_level,
  input  logic [31:0] in_tick_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_action,
  output logic [11:0] out_frame_index,
  output logic        out_led_on,
  output logic        out_engaged,
  output logic [1:0]  out_mode_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_long_press_ticks
);

  logic                 s1_valid_r;
  ltc_pkg::ltc_item_t   s1_item_r;
  logic                 out_valid_r;
  ltc_pkg::ltc_result_t out_res_r;
  ltc_pkg::ltc_result_t core_res;
  logic [15:0]          lpt_r;
  logic                 s1_adv;
  logic                 s1_load;

  // Pipeline flow control.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign s1_load  = in_valid && !in_stall;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpt_r <= ltc_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lpt_r <= cfg_long_press_ticks;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r.operation    <= in_operation;
      s1_item_r.button_level <= in_button_level;
      s1_item_r.tick_time    <= in_tick_time;
    end
  end

  // Transport state and logic.
  ltc_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (s1_adv),
    .item             (s1_item_r),
    .long_press_ticks (lpt_r),
    .result           (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_action = out_res_r.frame_action;
  assign out_frame_index  = out_res_r.frame_index;
  assign out_led_on       = out_res_r.led_on;
  assign out_engaged      = out_res_r.engaged;
  assign out_mode_now     = out_res_r.mode_now;

  // The engaged flag always follows the reported mode.
  a_engaged_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_engaged == (out_mode_now != ltc_pkg::MODE_BYPASS)))
    else $error("engaged flag disagrees with mode");

  // No store action means index zero.
  a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_action == ltc_pkg::ACT_NONE) |-> (out_frame_index == '0))
    else $error("index set without a store action");

  // A record write leaves the looper recording or, when the store fills, playing.
  a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_action == ltc_pkg::ACT_WRITE) |->
      (out_mode_now == ltc_pkg::MODE_RECORD || out_mode_now == ltc_pkg::MODE_PLAY))
    else $error("record write reported in a wrong mode");

  // The request side only stalls when the request register is occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("request stall without a full pipeline");

endmodule

@@ rtl/ltc_core.sv @@
// Transport state and next-state logic of the looper: mode, loop position,
// loop length, button history, press start and LED level. Uses ltc_pkg.
module ltc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  ltc_pkg::ltc_item_t  item,
  input  logic [15:0]         long_press_ticks,
  output ltc_pkg::ltc_result_t result
);

  logic [1:0]               mode_r, mode_nxt;
  logic [ltc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [ltc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                     btn_r, btn_nxt;
  logic [31:0]              press_start_r, press_start_nxt;
  logic                     led_r, led_nxt;

  logic [ltc_pkg::LEN_W-1:0] pos_inc;
  logic [31:0]              held;
  logic [1:0]               action;
  logic [ltc_pkg::POS_W-1:0] index;

  // Next state for one request.
  always_comb begin
    mode_nxt        = mode_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    btn_nxt         = btn_r;
    press_start_nxt = press_start_r;
    led_nxt         = led_r;
    action          = ltc_pkg::ACT_NONE;
    index           = '0;
    pos_inc         = {1'b0, pos_r} + ltc_pkg::LEN_W'(1);
    held            = '0;

    if (item.operation == ltc_pkg::OP_TICK) begin
      btn_nxt = item.button_level;
      // A press steps the transport.
      if (item.button_level && !btn_r) begin
        press_start_nxt = item.tick_time;
        case (mode_r)
          ltc_pkg::MODE_BYPASS: begin
            len_nxt  = '0;
            pos_nxt  = '0;
            mode_nxt = ltc_pkg::MODE_RECORD;
          end
          ltc_pkg::MODE_RECORD: begin
            pos_nxt  = '0;
            mode_nxt = ltc_pkg::MODE_PLAY;
          end
          ltc_pkg::MODE_PLAY: begin
            mode_nxt = ltc_pkg::MODE_OVERDUB;
          end
          default: begin
            mode_nxt = ltc_pkg::MODE_PLAY;
          end
        endcase
      end

      held = item.tick_time - press_start_nxt;

      // Long press check and LED level.
      if (btn_nxt && mode_nxt != ltc_pkg::MODE_BYPASS) begin
        if (held > {16'b0, long_press_ticks}) begin
          len_nxt  = '0;
          pos_nxt  = '0;
          mode_nxt = ltc_pkg::MODE_BYPASS;
        end else begin
          led_nxt = |(item.tick_time & ltc_pkg::FAST_BLINK_MASK);
        end
      end else if (mode_nxt == ltc_pkg::MODE_RECORD ||
                   mode_nxt == ltc_pkg::MODE_OVERDUB) begin
        led_nxt = |(item.tick_time & ltc_pkg::SLOW_BLINK_MASK);
      end else if (mode_nxt == ltc_pkg::MODE_PLAY) begin
        led_nxt = (pos_nxt > ltc_pkg::POS_W'(ltc_pkg::PLAY_LED_POS));
      end else begin
        led_nxt = 1'b0;
      end
    end else begin
      // Frame boundary: pick the store action and move the position.
      case (mode_r)
        ltc_pkg::MODE_PLAY, ltc_pkg::MODE_OVERDUB: begin
          action  = (mode_r == ltc_pkg::MODE_PLAY) ? ltc_pkg::ACT_READ : ltc_pkg::ACT_RMW;
          index   = pos_r;
          pos_nxt = (pos_inc >= len_r) ? '0 : pos_inc[ltc_pkg::POS_W-1:0];
        end
        ltc_pkg::MODE_RECORD: begin
          action  = ltc_pkg::ACT_WRITE;
          index   = pos_r;
          len_nxt = pos_inc;
          if (pos_inc >= ltc_pkg::LEN_W'(ltc_pkg::LOOP_FRAMES)) begin
            pos_nxt  = '0;
            mode_nxt = ltc_pkg::MODE_PLAY;
          end else begin
            pos_nxt = pos_inc[ltc_pkg::POS_W-1:0];
          end
        end
        default: begin
          action = ltc_pkg::ACT_NONE;
        end
      endcase
    end
  end

  // Result of this request: old position as index, the rest after the update.
  always_comb begin
    result.frame_action = action;
    result.frame_index  = index;
    result.led_on       = led_nxt;
    result.engaged      = (mode_nxt != ltc_pkg::MODE_BYPASS);
    result.mode_now     = mode_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ltc_pkg::MODE_BYPASS;
      pos_r  <= '0;
      len_r  <= '0;
      btn_r  <= 1'b0;
      led_r  <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      btn_r  <= btn_nxt;
      led_r  <= led_nxt;
    end
  end

  // Press start time is only read while the button is held.
  always_ff @(posedge clk) begin
    if (step_en) begin
      press_start_r <= press_start_nxt;
    end
  end

endmodule

@@ tb/tb_looper_transport_controller.sv @@
// Self-checking testbench for the looper transport controller.
// A transaction-level predictor is compared against every result; it depends
// only on ltc_pkg and the looper_transport_controller top level.
`timescale 1ns / 100ps

module tb_looper_transport_controller;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 200;

  // Tracks the transport state and holds the results each request should produce.
  class transport_tracker;
    logic [15:0]               hold_limit;
    logic [1:0]                mode;
    logic [ltc_pkg::POS_W-1:0] position;
    logic [ltc_pkg::LEN_W-1:0] loop_len;
    logic                      button_down;
    logic [31:0]               press_time;
    logic                      led;
    ltc_pkg::ltc_result_t      outcomes[$];
    int                        errors;
    int                        checked;
    int                        requests;
    int                        long_presses;
    int                        full_stores;

    function new();
      hold_limit   = ltc_pkg::LONG_PRESS_RESET;
      mode         = ltc_pkg::MODE_BYPASS;
      position     = '0;
      loop_len     = '0;
      button_down  = 1'b0;
      press_time   = '0;
      led          = 1'b0;
      errors       = 0;
      checked      = 0;
      requests     = 0;
      long_presses = 0;
      full_stores  = 0;
    endfunction

    // Step the transport for one accepted request and queue its result.
    function void take_request(ltc_pkg::ltc_item_t req);
      ltc_pkg::ltc_result_t res;
      logic [31:0] held;
      res = '0;
      requests++;
      if (req.operation == ltc_pkg::OP_TICK) begin
        // A rising button edge steps the mode.
        if (req.button_level != button_down) begin
          button_down = req.button_level;
          if (req.button_level) begin
            press_time = req.tick_time;
            case (mode)
              ltc_pkg::MODE_BYPASS: begin
                loop_len = '0;
                position = '0;
                mode     = ltc_pkg::MODE_RECORD;
              end
              ltc_pkg::MODE_RECORD: begin
                position = '0;
                mode     = ltc_pkg::MODE_PLAY;
              end
              ltc_pkg::MODE_PLAY: mode = ltc_pkg::MODE_OVERDUB;
              default:            mode = ltc_pkg::MODE_PLAY;
            endcase
          end
        end
        // A held button either blinks fast or fires the long press.
        if (button_down && mode != ltc_pkg::MODE_BYPASS) begin
          held = req.tick_time - press_time;
          if (held > {16'd0, hold_limit}) begin
            loop_len = '0;
            position = '0;
            mode     = ltc_pkg::MODE_BYPASS;
            long_presses++;
          end else begin
            led = |(req.tick_time & ltc_pkg::FAST_BLINK_MASK);
          end
        end else if (mode == ltc_pkg::MODE_RECORD || mode == ltc_pkg::MODE_OVERDUB) begin
          led = |(req.tick_time & ltc_pkg::SLOW_BLINK_MASK);
        end else if (mode == ltc_pkg::MODE_PLAY) begin
          led = (position > ltc_pkg::POS_W'(ltc_pkg::PLAY_LED_POS));
        end else begin
          led = 1'b0;
        end
      end else begin
        // A frame boundary picks the store action and moves the position on.
        case (mode)
          ltc_pkg::MODE_PLAY, ltc_pkg::MODE_OVERDUB: begin
            res.frame_action = (mode == ltc_pkg::MODE_PLAY) ? ltc_pkg::ACT_READ
                                                            : ltc_pkg::ACT_RMW;
            res.frame_index  = position;
            if ({1'b0, position} + 1'b1 >= loop_len) position = '0;
            else position = position + 1'b1;
          end
          ltc_pkg::MODE_RECORD: begin
            res.frame_action = ltc_pkg::ACT_WRITE;
            res.frame_index  = position;
            loop_len = {1'b0, position} + 1'b1;
            if (loop_len >= ltc_pkg::LEN_W'(ltc_pkg::LOOP_FRAMES)) begin
              position = '0;
              mode     = ltc_pkg::MODE_PLAY;
              full_stores++;
            end else begin
              position = position + 1'b1;
            end
          end
          default: ;
        endcase
      end
      res.led_on   = led;
      res.engaged  = (mode != ltc_pkg::MODE_BYPASS);
      res.mode_now = mode;
      outcomes.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest outstanding one.
    function void match_result(ltc_pkg::ltc_result_t got);
      ltc_pkg::ltc_result_t want;
      if (outcomes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = outcomes.pop_front();
      checked++;
      compare_field("frame_action", 32'(want.frame_action), 32'(got.frame_action));
      compare_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
      compare_field("led_on", 32'(want.led_on), 32'(got.led_on));
      compare_field("engaged", 32'(want.engaged), 32'(got.engaged));
      compare_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic        in_button_level = 1'b0;
  logic [31:0] in_tick_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_action;
  logic [11:0] out_frame_index;
  logic        out_led_on;
  logic        out_engaged;
  logic [1:0]  out_mode_now;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_long_press_ticks = '0;

  transport_tracker tracker = new();

  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_max = 1;
  int          hold_left = 0;
  int          hold_writes = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  logic [31:0] clock_now = '0;
  logic        button_now = 1'b0;
  ltc_pkg::ltc_result_t seen;

  looper_transport_controller dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_button_level      (in_button_level),
    .in_tick_time         (in_tick_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_action     (out_frame_action),
    .out_frame_index      (out_frame_index),
    .out_led_on           (out_led_on),
    .out_engaged          (out_engaged),
    .out_mode_now         (out_mode_now),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_long_press_ticks (cfg_long_press_ticks)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The receiver switches between free flow, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Every result taken by the receiver is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.frame_action = out_frame_action;
      seen.frame_index  = out_frame_index;
      seen.led_on       = out_led_on;
      seen.engaged      = out_engaged;
      seen.mode_now     = out_mode_now;
      tracker.match_result(seen);
    end
  end

  // Offer one request, wait for it to be taken, then maybe idle for a while.
  task automatic send_request(input ltc_pkg::ltc_item_t req);
    in_valid        <= 1'b1;
    in_operation    <= req.operation;
    in_button_level <= req.button_level;
    in_tick_time    <= req.tick_time;
    do @(posedge clk); while (in_stall);
    tracker.take_request(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      gap_max    = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_tick(input logic level, input logic [31:0] stamp);
    ltc_pkg::ltc_item_t req;
    req.operation    = ltc_pkg::OP_TICK;
    req.button_level = level;
    req.tick_time    = stamp;
    send_request(req);
  endtask

  // Frame requests carry random button and time values that the block ignores.
  task automatic send_frame();
    ltc_pkg::ltc_item_t req;
    req.operation    = ltc_pkg::OP_FRAME;
    req.button_level = 1'($urandom_range(0, 1));
    req.tick_time    = $urandom();
    send_request(req);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold_limit(input logic [15:0] value);
    settle_block();
    cfg_valid            <= 1'b1;
    cfg_long_press_ticks <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.hold_limit = value;
    hold_writes++;
  endtask

  // Hand-picked sequence through every mode and the corner cases of the LED and loop.
  task automatic run_directed();
    send_frame();                              // Bypass frames do nothing.
    send_tick(1'b1, 32'hFFFF_FFC0);            // Record; the hold time wraps below.
    send_tick(1'b1, 32'h0000_0300);
    send_tick(1'b0, 32'h0000_0380);
    repeat (7) send_frame();                   // Record seven frames.
    send_tick(1'b1, 32'h0000_0400);            // Play from the start.
    send_tick(1'b0, 32'h0000_0410);
    repeat (6) send_frame();
    send_tick(1'b0, 32'h0000_0420);            // Position past five lights the LED.
    send_tick(1'b1, 32'h0000_0500);            // Overdub.
    send_tick(1'b0, 32'h0000_0510);
    send_frame();                              // Last frame wraps the position.
    send_tick(1'b1, 32'h0000_0600);            // Back to play and keep holding.
    send_tick(1'b1, 32'h0000_0600 + 32'd1000); // Exactly at the hold limit.
    send_tick(1'b1, 32'h0000_0600 + 32'd1001); // Long press fires; LED holds.
    send_tick(1'b1, 32'h0000_2000);            // Still held while bypassed.
    send_tick(1'b0, 32'h0000_2010);
    // Record nothing, then play an empty loop.
    send_tick(1'b1, 32'h0000_2100);
    send_tick(1'b0, 32'h0000_2110);
    send_tick(1'b1, 32'h0000_2120);
    send_tick(1'b0, 32'h0000_2130);
    send_frame();
    send_frame();
    clock_now  = 32'h0000_2200;
    button_now = 1'b0;
    hold_left  = 0;
  endtask

  // Force bypass with a long hold, then record until the store is full.
  task automatic fill_store();
    send_tick(1'b0, clock_now);
    send_tick(1'b1, clock_now + 32'd16);
    send_tick(1'b1, clock_now + 32'd70016);
    clock_now = clock_now + 32'd70032;
    send_tick(1'b0, clock_now);
    send_tick(1'b1, clock_now + 32'd8);
    send_tick(1'b0, clock_now + 32'd16);
    repeat (ltc_pkg::LOOP_FRAMES) send_frame();
    clock_now  = clock_now + 32'd32;
    button_now = 1'b0;
    hold_left  = 0;
  endtask

  // Button sessions with advancing time, frames in between, and some stray ticks.
  task automatic run_random(input int count);
    int step_max;
    int pick;
    step_max = int'(tracker.hold_limit) / 4 + 4;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) settle_block();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        clock_now  = $urandom();
        button_now = 1'($urandom_range(0, 1));
        send_tick(button_now, clock_now);
      end else if (pick < 50) begin
        send_frame();
      end else begin
        clock_now = clock_now + $urandom_range(0, step_max);
        if (hold_left == 0) begin
          button_now = !button_now;
          hold_left  = button_now ? $urandom_range(0, 12) : $urandom_range(0, 5);
        end else begin
          hold_left--;
        end
        send_tick(button_now, clock_now);
      end
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    fill_store();
    run_random(300);
    write_hold_limit(16'd0);
    run_random(300);
    write_hold_limit(16'hFFFF);
    run_random(300);
    write_hold_limit(16'($urandom_range(1, 4000)));
    run_random(350);
    write_hold_limit(16'd1);
    run_random(300);
    write_hold_limit(16'($urandom()));
    run_random(400);
    settle_block();
    $display("Ran %0d requests and checked %0d results over %0d hold limit settings.",
             tracker.requests, tracker.checked, hold_writes + 1);
    $display("Saw %0d long presses and %0d recordings that filled the store.",
             tracker.long_presses, tracker.full_stores);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
